// File: rtl/core/s256br_pkg.sv
// Shared types, register map codes and SHA-256 constants for the register-mapped core.
package s256br_pkg;

    typedef logic [31:0] word_t;
    typedef logic [7:0][31:0] hash_t;
    typedef logic [15:0][31:0] block_t;

    // Sequencer commands shared by the schedule and round units
    typedef struct packed {
        logic       load;
        logic       step;
        logic [5:0] round;
    } ctl_t;

    // Access kinds
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // Register word map
    localparam logic [4:0] WORD_CTRL   = 5'd0;
    localparam logic [4:0] WORD_STATUS = 5'd1;
    localparam logic [4:0] WORD_BLOCK  = 5'd2;
    localparam logic [4:0] WORD_DIGEST = 5'(32'h48 / 4);
    localparam int         BLOCK_WORDS  = 16;
    localparam int         DIGEST_WORDS = 8;

    // Control and status bit positions
    localparam int CTRL_INIT_BIT  = 1;
    localparam int CTRL_NEXT_BIT  = 2;
    localparam int CTRL_CLEAR_BIT = 3;
    localparam int STAT_DONE_BIT  = 1;
    localparam int STAT_VALID_BIT = 2;

    localparam word_t HASH_START [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// File: rtl/core/s256br_req_if.sv
// Request channel: one bus access per beat.
interface s256br_req_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [4:0] word_index;
    logic [31:0] write_data;

    modport source (output valid, output func, output word_index, output write_data,
                    input ready);
    modport sink (input valid, input func, input word_index, input write_data,
                  output ready);
endinterface

// File: rtl/core/s256br_rsp_if.sv
// Response channel: one read word per beat.
interface s256br_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;

    modport source (output valid, output read_data, input ready);
    modport sink (input valid, input read_data, output ready);
endinterface

// File: rtl/core/s256br_sched.sv
// Message schedule: sliding 16-word window producing W[t] one per round.
module s256br_sched (
    input  logic                 clk,
    input  s256br_pkg::ctl_t     ctl,
    input  s256br_pkg::block_t   block,
    output s256br_pkg::word_t    w_cur
);

    s256br_pkg::word_t win_reg [16];
    s256br_pkg::word_t s0;
    s256br_pkg::word_t s1;
    s256br_pkg::word_t w_new;

    // Next expansion word from the window
    always_comb
    begin
        s0 = s256br_pkg::rotr(win_reg[1], 7) ^ s256br_pkg::rotr(win_reg[1], 18)
             ^ (win_reg[1] >> 3);
        s1 = s256br_pkg::rotr(win_reg[14], 17) ^ s256br_pkg::rotr(win_reg[14], 19)
             ^ (win_reg[14] >> 10);
        w_new = win_reg[0] + s0 + win_reg[9] + s1;
    end

    assign w_cur = win_reg[0];

    // Load the block, then shift one word per round
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            for (int i = 0; i < 16; i++)
            begin
                win_reg[i] <= block[i];
            end
        end
        else if (ctl.step)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= w_new;
        end
    end

endmodule

// File: rtl/core/s256br_round.sv
// Compression round unit: working variables a..h, one round per step.
module s256br_round (
    input  logic                 clk,
    input  s256br_pkg::ctl_t     ctl,
    input  s256br_pkg::hash_t    hash_in,
    input  s256br_pkg::word_t    w_cur,
    output s256br_pkg::hash_t    vars
);

    s256br_pkg::hash_t v_reg;
    s256br_pkg::word_t big0;
    s256br_pkg::word_t big1;
    s256br_pkg::word_t ch;
    s256br_pkg::word_t maj;
    s256br_pkg::word_t t1;
    s256br_pkg::word_t t2;

    // One SHA-256 round
    always_comb
    begin
        big1 = s256br_pkg::rotr(v_reg[4], 6) ^ s256br_pkg::rotr(v_reg[4], 11)
               ^ s256br_pkg::rotr(v_reg[4], 25);
        ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1   = v_reg[7] + big1 + ch + s256br_pkg::ROUND_K[ctl.round] + w_cur;
        big0 = s256br_pkg::rotr(v_reg[0], 2) ^ s256br_pkg::rotr(v_reg[0], 13)
               ^ s256br_pkg::rotr(v_reg[0], 22);
        maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2   = big0 + maj;
    end

    assign vars = v_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            v_reg <= hash_in;
        end
        else if (ctl.step)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

endmodule

// File: rtl/core/sha256_core_behind_registers_core.sv
// Top level: register file, bus decode and round sequencer of the SHA-256 core.
//
//   channel  dir  payload                          beat
//   req      in   func, word_index, write_data     one 32-bit access
//   rsp      out  read_data                        one word per access
//
// A read or a plain write gives its response beat the cycle after it is taken.
// A control write with init or next runs a load step, the 64 rounds
// on the shared round unit and a digest add; its response (zero) follows.
// req.ready is low while a compression runs or an unclaimed response blocks.
// rsp.ready low holds the response register; no other stall source exists.
// Reset clears the block, the digest and both status flags.
module sha256_core_behind_registers_core (
    input  logic       clk,
    input  logic       rst_n,
    s256br_req_if.sink   req,
    s256br_rsp_if.source rsp
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOAD   = 2'd1;
    localparam logic [1:0] ST_ROUND  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [5:0]         round_reg;
    s256br_pkg::word_t  message_reg [16];
    s256br_pkg::word_t  digest_reg [8];
    logic               done_reg;
    logic               valid_reg;
    logic               out_valid_reg;
    s256br_pkg::word_t  out_data_reg;

    logic               in_ready;
    logic               accept;
    logic               is_write;
    logic               ctrl_write;
    logic               do_clear;
    logic               do_init;
    logic               start;
    logic               blk_hit;
    logic               dig_hit;
    logic [3:0]         blk_idx;
    logic [2:0]         dig_idx;
    logic [4:0]         blk_off;
    logic [4:0]         dig_off;
    s256br_pkg::word_t  rd_val;
    s256br_pkg::ctl_t   ctl;
    s256br_pkg::block_t block;
    s256br_pkg::hash_t  hash_in;
    s256br_pkg::hash_t  vars;
    s256br_pkg::word_t  w_cur;

    // Handshake and access decode
    assign in_ready   = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign req.ready  = in_ready;
    assign accept     = req.valid && in_ready;
    assign is_write   = (req.func == s256br_pkg::FUNC_WRITE);
    assign ctrl_write = accept && is_write && (req.word_index == s256br_pkg::WORD_CTRL);
    assign do_clear   = ctrl_write && req.write_data[s256br_pkg::CTRL_CLEAR_BIT];
    assign do_init    = ctrl_write && req.write_data[s256br_pkg::CTRL_INIT_BIT];
    assign start      = ctrl_write && (req.write_data[s256br_pkg::CTRL_INIT_BIT]
                                       || req.write_data[s256br_pkg::CTRL_NEXT_BIT]);
    assign blk_off    = req.word_index - s256br_pkg::WORD_BLOCK;
    assign dig_off    = req.word_index - s256br_pkg::WORD_DIGEST;
    assign blk_idx    = blk_off[3:0];
    assign dig_idx    = dig_off[2:0];
    assign blk_hit    = (req.word_index >= s256br_pkg::WORD_BLOCK)
                        && (blk_off < 5'(s256br_pkg::BLOCK_WORDS));
    assign dig_hit    = (req.word_index >= s256br_pkg::WORD_DIGEST)
                        && (dig_off < 5'(s256br_pkg::DIGEST_WORDS));

    // Read mux
    always_comb
    begin
        rd_val = '0;
        if (!is_write)
        begin
            if (req.word_index == s256br_pkg::WORD_STATUS)
            begin
                rd_val[s256br_pkg::STAT_DONE_BIT]  = done_reg;
                rd_val[s256br_pkg::STAT_VALID_BIT] = valid_reg;
            end
            else if (blk_hit)
            begin
                rd_val = message_reg[blk_idx];
            end
            else if (dig_hit)
            begin
                rd_val = digest_reg[dig_idx];
            end
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        ctl.load   = 1'b0;
        ctl.step   = 1'b0;
        ctl.round  = round_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                ctl.load   = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                ctl.step = 1'b1;
                if (round_reg == 6'd63)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            round_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_LOAD)
            begin
                round_reg <= '0;
            end
            else if (state_reg == ST_ROUND)
            begin
                round_reg <= round_reg + 6'd1;
            end
        end
    end

    // Block words: bus writes and clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                message_reg[i] <= '0;
            end
        end
        else if (do_clear)
        begin
            for (int i = 0; i < 16; i++)
            begin
                message_reg[i] <= '0;
            end
        end
        else if (accept && is_write && blk_hit)
        begin
            message_reg[blk_idx] <= req.write_data;
        end
    end

    // Digest: IV load on init, feed-forward add after the last round
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                digest_reg[i] <= '0;
            end
        end
        else if (do_init)
        begin
            for (int i = 0; i < 8; i++)
            begin
                digest_reg[i] <= s256br_pkg::HASH_START[i];
            end
        end
        else if (state_reg == ST_FINISH)
        begin
            for (int i = 0; i < 8; i++)
            begin
                digest_reg[i] <= digest_reg[i] + vars[i];
            end
        end
    end

    // Status flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else if (do_clear)
        begin
            done_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else if (state_reg == ST_FINISH)
        begin
            done_reg  <= 1'b1;
            valid_reg <= 1'b1;
        end
    end

    // Response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((accept && !start) || (state_reg == ST_FINISH))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !start)
        begin
            out_data_reg <= rd_val;
        end
        else if (state_reg == ST_FINISH)
        begin
            out_data_reg <= '0;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_data_reg;

    // Datapath units
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            block[i] = message_reg[i];
        end
        for (int i = 0; i < 8; i++)
        begin
            hash_in[i] = digest_reg[i];
        end
    end

    s256br_sched u_sched (
        .clk   (clk),
        .ctl   (ctl),
        .block (block),
        .w_cur (w_cur)
    );

    s256br_round u_round (
        .clk     (clk),
        .ctl     (ctl),
        .hash_in (hash_in),
        .w_cur   (w_cur),
        .vars    (vars)
    );

    // Checks
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !req.ready)
        else $error("request taken during compression");

    a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (state_reg == ST_LOAD))
        else $error("compression start did not enter load");

    a_last_round: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && round_reg == 6'd63) |=> (state_reg == ST_FINISH))
        else $error("round count overran");

    a_finish_responds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |=> (rsp.valid && done_reg && valid_reg))
        else $error("finish without response and flags");

    a_round_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> !out_valid_reg)
        else $error("response register occupied during compression");

endmodule

// File: tb/sv/sha256_core_behind_registers_core_tb.sv
// Testbench for the register-mapped SHA-256 core: bus accesses checked against a digest model.
module sha256_core_behind_registers_core_tb;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 80;
    localparam int HOLD_CYCLES  = 300;

    localparam s256br_pkg::word_t CTRL_INIT  =
        s256br_pkg::word_t'(1) << s256br_pkg::CTRL_INIT_BIT;
    localparam s256br_pkg::word_t CTRL_NEXT  =
        s256br_pkg::word_t'(1) << s256br_pkg::CTRL_NEXT_BIT;
    localparam s256br_pkg::word_t CTRL_CLEAR =
        s256br_pkg::word_t'(1) << s256br_pkg::CTRL_CLEAR_BIT;
    localparam s256br_pkg::word_t CTRL_BITS  = CTRL_INIT | CTRL_NEXT | CTRL_CLEAR;
    localparam s256br_pkg::word_t STAT_DONE  =
        s256br_pkg::word_t'(1) << s256br_pkg::STAT_DONE_BIT;
    localparam s256br_pkg::word_t STAT_VALID =
        s256br_pkg::word_t'(1) << s256br_pkg::STAT_VALID_BIT;

    // FIPS 180-4 initial hash value and round constants, kept apart from the RTL copy
    localparam s256br_pkg::word_t IV_WORDS [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam s256br_pkg::word_t ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Register image of the core plus the read words still owed by it
    class sha_reg_scoreboard;
        s256br_pkg::word_t msg_words [16];
        s256br_pkg::word_t hash_words [8];
        bit    done_bit;
        bit    valid_bit;
        s256br_pkg::word_t owed_reads [$];
        int    fails;
        int    n_reads;
        int    n_writes;
        int    n_compressions;

        function new();
            foreach (msg_words[i]) msg_words[i] = '0;
            foreach (hash_words[i]) hash_words[i] = '0;
            done_bit = 1'b0;
            valid_bit = 1'b0;
            fails = 0;
            n_reads = 0;
            n_writes = 0;
            n_compressions = 0;
        endfunction

        function s256br_pkg::word_t ror(s256br_pkg::word_t x, int n);
            logic [63:0] twice;
            twice = {x, x} >> n;
            return twice[31:0];
        endfunction

        // One 64-round compression of the block into the running hash
        function void compress_block();
            s256br_pkg::word_t w [64];
            s256br_pkg::word_t v [8];
            s256br_pkg::word_t s0, s1, t1, t2, e, a;
            for (int t = 0; t < 16; t++) w[t] = msg_words[t];
            for (int t = 16; t < 64; t++)
            begin
                s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
                s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
                w[t] = w[t-16] + s0 + w[t-7] + s1;
            end
            foreach (v[i]) v[i] = hash_words[i];
            for (int t = 0; t < 64; t++)
            begin
                e = v[4];
                a = v[0];
                t1 = v[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25))
                     + ((e & v[5]) ^ (~e & v[6])) + ROUND_CONST[t] + w[t];
                t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22))
                     + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            foreach (hash_words[i]) hash_words[i] += v[i];
        endfunction

        // Apply one accepted access and queue the word it must return
        function void note_access(logic func, logic [4:0] idx, s256br_pkg::word_t data);
            s256br_pkg::word_t rd;
            int    slot;
            int    dslot;
            rd = '0;
            slot = int'(idx) - int'(s256br_pkg::WORD_BLOCK);
            dslot = int'(idx) - int'(s256br_pkg::WORD_DIGEST);
            if (func == s256br_pkg::FUNC_WRITE)
            begin
                n_writes++;
                if (idx == s256br_pkg::WORD_CTRL)
                begin
                    // clear goes first, then init/next (init wins over next)
                    if ((data & CTRL_CLEAR) != 0)
                    begin
                        done_bit = 1'b0;
                        valid_bit = 1'b0;
                        foreach (msg_words[i]) msg_words[i] = '0;
                    end
                    if ((data & (CTRL_INIT | CTRL_NEXT)) != 0)
                    begin
                        if ((data & CTRL_INIT) != 0)
                            foreach (hash_words[i]) hash_words[i] = IV_WORDS[i];
                        compress_block();
                        done_bit = 1'b1;
                        valid_bit = 1'b1;
                        n_compressions++;
                    end
                end
                else if (slot >= 0 && slot < s256br_pkg::BLOCK_WORDS)
                    msg_words[slot] = data;
            end
            else
            begin
                n_reads++;
                if (idx == s256br_pkg::WORD_STATUS)
                    rd = (done_bit ? STAT_DONE : '0) | (valid_bit ? STAT_VALID : '0);
                else if (slot >= 0 && slot < s256br_pkg::BLOCK_WORDS)
                    rd = msg_words[slot];
                else if (dslot >= 0 && dslot < s256br_pkg::DIGEST_WORDS)
                    rd = hash_words[dslot];
            end
            owed_reads.push_back(rd);
        endfunction

        // Compare a response beat with the oldest owed word
        function void check_read(s256br_pkg::word_t got);
            s256br_pkg::word_t want;
            if (owed_reads.size() == 0)
            begin
                $error("read_data: expected no beat, actual %08h", got);
                fails++;
            end
            else
            begin
                want = owed_reads.pop_front();
                if (got !== want)
                begin
                    $error("read_data: expected %08h, actual %08h", want, got);
                    fails++;
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    s256br_req_if req_ch();
    s256br_rsp_if rsp_ch();

    sha256_core_behind_registers_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    sha_reg_scoreboard sb;
    int items_sent = 0;
    int send_idle_pct = 0;
    int rsp_stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int cycle_count = 0;

    always #CLK_HALF clk = ~clk;

    // Response side: random stalls, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= ($urandom_range(99, 0) >= rsp_stall_pct);
    end

    // Beat monitor: check responses first, then note new accesses
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_read(rsp_ch.read_data);
            if (req_ch.valid && req_ch.ready)
                sb.note_access(req_ch.func, req_ch.word_index, req_ch.write_data);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $error("watchdog expired after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic s256br_pkg::word_t pick_data();
        case ($urandom_range(7, 0))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Offer one access, with random idle cycles ahead of it
    task automatic send_access(input logic f, input logic [4:0] idx,
                               input s256br_pkg::word_t data);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func <= f;
        req_ch.word_index <= idx;
        req_ch.write_data <= data;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        items_sent++;
    endtask

    // Drop valid and let the monitor note the last accepted access before waiting on owed reads
    task automatic await_all_reads();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.owed_reads.size() != 0) @(posedge clk);
    endtask

    task automatic send_noise();
        send_access(logic'($urandom_range(1, 0)), 5'($urandom_range(31, 0)), pick_data());
    endtask

    // Load a block, start a compression, read back status and digest
    task automatic hash_sequence();
        s256br_pkg::word_t op;
        int    n_digest;
        if ($urandom_range(7, 0) == 0)
            send_access(s256br_pkg::FUNC_WRITE, s256br_pkg::WORD_CTRL, CTRL_CLEAR);
        for (int i = 0; i < s256br_pkg::BLOCK_WORDS; i++)
            if ($urandom_range(7, 0) != 0)
                send_access(s256br_pkg::FUNC_WRITE, s256br_pkg::WORD_BLOCK + 5'(i),
                            pick_data());
        if ($urandom_range(3, 0) == 0)
            send_access(s256br_pkg::FUNC_READ,
                        s256br_pkg::WORD_BLOCK + 5'($urandom_range(15, 0)), $urandom);
        case ($urandom_range(4, 0))
            0: op = CTRL_INIT;
            1: op = CTRL_NEXT;
            2: op = CTRL_INIT | CTRL_NEXT;
            3: op = CTRL_CLEAR | CTRL_INIT;
            default: op = CTRL_CLEAR | CTRL_NEXT;
        endcase
        if ($urandom_range(1, 0) == 1)
            op |= $urandom & ~CTRL_BITS;
        send_access(s256br_pkg::FUNC_WRITE, s256br_pkg::WORD_CTRL, op);
        send_access(s256br_pkg::FUNC_READ, s256br_pkg::WORD_STATUS, $urandom);
        n_digest = $urandom_range(s256br_pkg::DIGEST_WORDS, 1);
        for (int i = 0; i < n_digest; i++)
            send_access(s256br_pkg::FUNC_READ,
                        s256br_pkg::WORD_DIGEST + 5'($urandom_range(7, 0)), $urandom);
    endtask

    task automatic run_random(input int stop_at);
        while (items_sent < stop_at)
        begin
            if ($urandom_range(99, 0) < 65)
                hash_sequence();
            else
                send_noise();
        end
        await_all_reads();
    endtask

    task automatic run_directed();
        // reset values, control and unmapped reads
        send_access(s256br_pkg::FUNC_READ, s256br_pkg::WORD_STATUS, '0);
        send_access(s256br_pkg::FUNC_READ, s256br_pkg::WORD_DIGEST, '0);
        send_access(s256br_pkg::FUNC_READ, 5'd31, '1);
        send_access(s256br_pkg::FUNC_READ, s256br_pkg::WORD_CTRL, '0);
        // next before any init runs from the zero digest
        send_access(s256br_pkg::FUNC_WRITE, s256br_pkg::WORD_CTRL, CTRL_NEXT);
        send_access(s256br_pkg::FUNC_READ, s256br_pkg::WORD_DIGEST, '0);
        send_access(s256br_pkg::FUNC_READ, s256br_pkg::WORD_STATUS, '0);
        // padded "abc" block, init and next together
        send_access(s256br_pkg::FUNC_WRITE, s256br_pkg::WORD_BLOCK, 32'h61626380);
        send_access(s256br_pkg::FUNC_WRITE, s256br_pkg::WORD_BLOCK + 5'd15, 32'h00000018);
        send_access(s256br_pkg::FUNC_WRITE, s256br_pkg::WORD_CTRL, CTRL_INIT | CTRL_NEXT);
        send_access(s256br_pkg::FUNC_READ, s256br_pkg::WORD_DIGEST, '0);
        send_access(s256br_pkg::FUNC_READ, s256br_pkg::WORD_DIGEST + 5'd7, '0);
        // clear alone keeps the digest
        send_access(s256br_pkg::FUNC_WRITE, s256br_pkg::WORD_CTRL, CTRL_CLEAR);
        send_access(s256br_pkg::FUNC_READ, s256br_pkg::WORD_STATUS, '0);
        send_access(s256br_pkg::FUNC_READ, s256br_pkg::WORD_BLOCK, '0);
        send_access(s256br_pkg::FUNC_READ, s256br_pkg::WORD_DIGEST, '0);
        // clear with init and every other control bit set
        send_access(s256br_pkg::FUNC_WRITE, s256br_pkg::WORD_BLOCK + 5'd15, '1);
        send_access(s256br_pkg::FUNC_READ, s256br_pkg::WORD_BLOCK + 5'd15, '0);
        send_access(s256br_pkg::FUNC_WRITE, s256br_pkg::WORD_CTRL, '1);
        send_access(s256br_pkg::FUNC_READ, s256br_pkg::WORD_STATUS, '0);
        send_access(s256br_pkg::FUNC_READ, s256br_pkg::WORD_BLOCK + 5'd15, '0);
        // control bits outside init/next/clear do nothing
        send_access(s256br_pkg::FUNC_WRITE, s256br_pkg::WORD_CTRL, ~CTRL_BITS);
        // writes to read-only and unmapped words are dropped
        send_access(s256br_pkg::FUNC_WRITE, s256br_pkg::WORD_STATUS, '1);
        send_access(s256br_pkg::FUNC_WRITE, s256br_pkg::WORD_DIGEST + 5'd7, '1);
        send_access(s256br_pkg::FUNC_WRITE, 5'd31, '1);
        send_access(s256br_pkg::FUNC_READ, s256br_pkg::WORD_DIGEST + 5'd7, '0);
        await_all_reads();
    endtask

    initial
    begin
        sb = new();
        rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.func <= s256br_pkg::FUNC_READ;
        req_ch.word_index <= s256br_pkg::WORD_CTRL;
        req_ch.write_data <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // long response hold-off while accesses keep coming, then a full pause
        hold_request = HOLD_CYCLES;
        repeat (12) send_noise();
        await_all_reads();

        // no idling
        run_random(items_sent + 200);
        // sender mostly idle
        send_idle_pct = 71;
        run_random(items_sent + 220);
        // receiver mostly stalled
        send_idle_pct = 0;
        rsp_stall_pct = 71;
        run_random(items_sent + 220);
        // both idling now and then
        send_idle_pct = 20;
        rsp_stall_pct = 20;
        run_random(items_sent + 220);

        rsp_stall_pct = 0;
        await_all_reads();
        repeat (DRAIN_CYCLES) @(posedge clk);

        // every accepted access must have produced its beat
        if (sb.owed_reads.size() != 0)
        begin
            $error("read_data: expected %0d more beats, actual 0", sb.owed_reads.size());
            sb.fails++;
        end

        $display("Covered %0d accesses (%0d reads, %0d writes) and %0d compressions,",
                 items_sent, sb.n_reads, sb.n_writes, sb.n_compressions);
        $display("with all register words, control bit mixes, hold-off and four idle patterns.");
        if (sb.fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
